/* rtl/assert_macros.svh */
// assertion macros used by the checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with a reset that disables it
`define DIPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same on the block clock and reset
`define DIPC_ASSERT_CLK(lbl, prop, msg) \
   `DIPC_ASSERT(lbl, clock, reset, prop, msg)

`endif

/* rtl/dipc_pkg.sv */
// constants, register codes and helper functions of the depth to point projection
// no dependencies
`timescale 1ns / 1ps

package dipc_pkg;

   localparam int MAX_DIMENSION = 2048;

   localparam int SIZE_WIDTH  = 12;
   localparam int DEPTH_WIDTH = 24;
   localparam int FOCAL_WIDTH = 24;
   localparam int ANGLE_WIDTH = 28;
   localparam int POINT_WIDTH = 29;
   localparam int GREEN_WIDTH = 8;
   localparam int CNT_WIDTH   = $clog2(MAX_DIMENSION);

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 24;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT  = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERSE_FOCAL = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_DEPTH     = 8'd3;

   // reset values of the registers
   localparam logic [SIZE_WIDTH-1:0]  RST_IMAGE_WIDTH   = 12'd640;
   localparam logic [SIZE_WIDTH-1:0]  RST_IMAGE_HEIGHT  = 12'd480;
   localparam logic [FOCAL_WIDTH-1:0] RST_INVERSE_FOCAL = 24'd6540;
   localparam logic [DEPTH_WIDTH-1:0] RST_MIN_DEPTH     = 24'd655;

   // green ramp: (depth + 3.0) * 255 / 6.0 with depth in Q8.16
   localparam logic [DEPTH_WIDTH:0] GREEN_OFFSET = 25'd196608;
   localparam int GREEN_SCALE  = 255;
   localparam int GREEN_SHIFT  = 17;
   localparam int GREEN_LIMIT  = 768;
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;

   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [SIZE_WIDTH-1:0] eff_size(input logic [SIZE_WIDTH-1:0] v);
      logic [SIZE_WIDTH-1:0] r;
      r = v;
      if (v == '0) r = SIZE_WIDTH'(1);
      else if (int'(v) > MAX_DIMENSION) r = SIZE_WIDTH'(MAX_DIMENSION);
      return r;
   endfunction

   // -floor((size-1)*inv/2), saturated at the negative limit
   function automatic logic signed [ANGLE_WIDTH-1:0] start_angle(
      input logic [SIZE_WIDTH-1:0]  size,
      input logic [FOCAL_WIDTH-1:0] inv
   );
      logic [SIZE_WIDTH-1:0]             span;
      logic [SIZE_WIDTH+FOCAL_WIDTH-1:0] prod;
      logic [SIZE_WIDTH+FOCAL_WIDTH-2:0] half;
      logic signed [ANGLE_WIDTH-1:0]     r;
      span = eff_size(size) - SIZE_WIDTH'(1);
      prod = span * inv;
      half = prod[SIZE_WIDTH+FOCAL_WIDTH-1:1];
      if (half >= (SIZE_WIDTH+FOCAL_WIDTH-1)'(1) << (ANGLE_WIDTH-1)) r = ANGLE_MIN;
      else r = -$signed(half[ANGLE_WIDTH-1:0]);
      return r;
   endfunction

   // add one step, saturated at the positive limit
   function automatic logic signed [ANGLE_WIDTH-1:0] step_angle(
      input logic signed [ANGLE_WIDTH-1:0] a,
      input logic [FOCAL_WIDTH-1:0]        inv
   );
      logic signed [ANGLE_WIDTH:0]   n;
      logic signed [ANGLE_WIDTH-1:0] r;
      n = {a[ANGLE_WIDTH-1], a} + $signed({{(ANGLE_WIDTH+1-FOCAL_WIDTH){1'b0}}, inv});
      if (n > $signed({1'b0, ANGLE_MAX})) r = ANGLE_MAX;
      else r = n[ANGLE_WIDTH-1:0];
      return r;
   endfunction

endpackage

/* rtl/dipc_project.sv */
// projection of one depth onto one axis: -depth*angle, rounded and saturated
// depends on dipc_pkg
`timescale 1ns / 1ps

module dipc_project (
   input  logic [dipc_pkg::DEPTH_WIDTH-1:0]        depth,
   input  logic signed [dipc_pkg::ANGLE_WIDTH-1:0] angle,
   output logic signed [dipc_pkg::POINT_WIDTH-1:0] point
);
   import dipc_pkg::*;

   localparam int PROD_WIDTH = DEPTH_WIDTH + ANGLE_WIDTH;
   localparam int FRAC_DROP  = 22;

   logic                     neg;
   logic [ANGLE_WIDTH-1:0]   mag;
   logic [PROD_WIDTH-1:0]    prod;
   logic [PROD_WIDTH-1:0]    rounded;
   logic [PROD_WIDTH-FRAC_DROP-1:0] p;
   logic [POINT_WIDTH-1:0]   p_sat;

   always_comb begin
      neg     = angle[ANGLE_WIDTH-1];
      mag     = neg ? ANGLE_WIDTH'(-angle) : ANGLE_WIDTH'(angle);
      prod    = depth * mag;
      // halves away from zero on the magnitude
      rounded = prod + (PROD_WIDTH'(1) << (FRAC_DROP-1));
      p       = rounded[PROD_WIDTH-1:FRAC_DROP];
      if (p >= (PROD_WIDTH-FRAC_DROP)'(1) << (POINT_WIDTH-1))
         p_sat = POINT_WIDTH'(1) << (POINT_WIDTH-1);
      else
         p_sat = p[POINT_WIDTH-1:0];
      if (neg) begin
         // positive result, one below the magnitude limit at most
         if (p_sat[POINT_WIDTH-1]) point = {1'b0, {(POINT_WIDTH-1){1'b1}}};
         else point = $signed(p_sat);
      end else begin
         point = -$signed(p_sat);
      end
   end

endmodule

/* rtl/depth_image_to_point_cloud_core.sv */
// top level of the depth image to point cloud projection
// depends on dipc_pkg and dipc_project
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_depth
//   rsp      out        rsp_valid/rsp_stall  rsp_point_x/y/z, rsp_point_valid,
//                                            rsp_green_level, rsp_frame_end
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// one item per clock sustained while rsp_stall is low and no restart is
// pending; an accepted item passes an input register, then the two axis
// multipliers and the green ramp into the result register
// reset is synchronous; the cycle after reset and after every csr write the
// block stalls req while the start angles of the new frame are loaded
// rsp_stall holds the result register, and req stalls once the input
// register is also full
`timescale 1ns / 1ps

module depth_image_to_point_cloud_core (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [dipc_pkg::DEPTH_WIDTH-1:0]         req_depth,

   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [dipc_pkg::POINT_WIDTH-1:0]  rsp_point_x,
   output logic signed [dipc_pkg::POINT_WIDTH-1:0]  rsp_point_y,
   output logic [dipc_pkg::DEPTH_WIDTH-1:0]         rsp_point_z,
   output logic                                     rsp_point_valid,
   output logic [dipc_pkg::GREEN_WIDTH-1:0]         rsp_green_level,
   output logic                                     rsp_frame_end,

   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [dipc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [dipc_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   import dipc_pkg::*;

   // configuration registers
   logic [SIZE_WIDTH-1:0]  width_ff;
   logic [SIZE_WIDTH-1:0]  height_ff;
   logic [FOCAL_WIDTH-1:0] inv_focal_ff;
   logic [DEPTH_WIDTH-1:0] min_depth_ff;

   // frame restart pending: angles load from the current registers
   logic restart_ff;

   // raster position and running angles
   logic [CNT_WIDTH-1:0]          col_cnt_ff, col_cnt_in;
   logic [CNT_WIDTH-1:0]          row_cnt_ff, row_cnt_in;
   logic signed [ANGLE_WIDTH-1:0] col_angle_ff, col_angle_in;
   logic signed [ANGLE_WIDTH-1:0] row_angle_ff, row_angle_in;
   logic signed [ANGLE_WIDTH-1:0] col_start, row_start;
   logic [SIZE_WIDTH-1:0]         eff_w, eff_h;
   logic                          last_col, last_row;

   // input register
   logic                          s1_valid_ff, s1_valid_in;
   logic [DEPTH_WIDTH-1:0]        s1_depth_ff;
   logic signed [ANGLE_WIDTH-1:0] s1_col_angle_ff;
   logic signed [ANGLE_WIDTH-1:0] s1_row_angle_ff;
   logic                          s1_frame_end_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [POINT_WIDTH-1:0] rsp_x_ff, rsp_x_in;
   logic signed [POINT_WIDTH-1:0] rsp_y_ff, rsp_y_in;
   logic [DEPTH_WIDTH-1:0]        rsp_z_ff, rsp_z_in;
   logic                          rsp_pvalid_ff, rsp_pvalid_in;
   logic [GREEN_WIDTH-1:0]        rsp_green_ff, rsp_green_in;
   logic                          rsp_fend_ff;

   logic accept, advance, csr_write;

   // datapath between the registers
   logic signed [POINT_WIDTH-1:0] proj_x, proj_y;
   logic                          pt_valid;
   logic [DEPTH_WIDTH:0]          green_base;
   logic [DEPTH_WIDTH+8:0]        green_scaled;
   logic [DEPTH_WIDTH+8-GREEN_SHIFT:0] green_div;
   logic [19:0]                   green_third;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // result register moves when empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || restart_ff || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RST_IMAGE_WIDTH;
         height_ff    <= RST_IMAGE_HEIGHT;
         inv_focal_ff <= RST_INVERSE_FOCAL;
         min_depth_ff <= RST_MIN_DEPTH;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff     <= csr_data[SIZE_WIDTH-1:0];
            CSR_IMAGE_HEIGHT:  height_ff    <= csr_data[SIZE_WIDTH-1:0];
            CSR_INVERSE_FOCAL: inv_focal_ff <= csr_data[FOCAL_WIDTH-1:0];
            CSR_MIN_DEPTH:     min_depth_ff <= csr_data[DEPTH_WIDTH-1:0];
            default: ;  // unknown index still restarts the frame
         endcase
      end
   end

   // raster counters and angle accumulators
   always_comb begin
      eff_w     = eff_size(width_ff);
      eff_h     = eff_size(height_ff);
      col_start = start_angle(width_ff, inv_focal_ff);
      row_start = start_angle(height_ff, inv_focal_ff);
      last_col  = (int'(col_cnt_ff) + 1) >= int'(eff_w);
      last_row  = (int'(row_cnt_ff) + 1) >= int'(eff_h);

      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      col_angle_in = col_angle_ff;
      row_angle_in = row_angle_ff;

      if (csr_write) begin
         col_cnt_in = '0;
         row_cnt_in = '0;
      end else if (restart_ff) begin
         col_cnt_in   = '0;
         row_cnt_in   = '0;
         col_angle_in = col_start;
         row_angle_in = row_start;
      end else if (accept) begin
         if (last_col) begin
            col_cnt_in   = '0;
            col_angle_in = col_start;
            if (last_row) begin
               row_cnt_in   = '0;
               row_angle_in = row_start;
            end else begin
               row_cnt_in   = row_cnt_ff + CNT_WIDTH'(1);
               row_angle_in = step_angle(row_angle_ff, inv_focal_ff);
            end
         end else begin
            col_cnt_in   = col_cnt_ff + CNT_WIDTH'(1);
            col_angle_in = step_angle(col_angle_ff, inv_focal_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b1;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         restart_ff <= csr_write;
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // angles reload on the restart cycle that always follows reset
   always_ff @(posedge clock) begin
      col_angle_ff <= col_angle_in;
      row_angle_ff <= row_angle_in;
   end

   // input register: depth plus the raster state it was accepted under
   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_depth_ff     <= req_depth;
         s1_col_angle_ff <= col_angle_ff;
         s1_row_angle_ff <= row_angle_ff;
         s1_frame_end_ff <= last_col && last_row;
      end
   end

   // the two axis products
   dipc_project u_proj_x (
      .depth (s1_depth_ff),
      .angle (s1_col_angle_ff),
      .point (proj_x)
   );

   dipc_project u_proj_y (
      .depth (s1_depth_ff),
      .angle (s1_row_angle_ff),
      .point (proj_y)
   );

   // green ramp: floor((d + 3.0)*255 / 6.0), clamped; /3 by reciprocal
   always_comb begin
      pt_valid     = s1_depth_ff > min_depth_ff;
      green_base   = {1'b0, s1_depth_ff} + GREEN_OFFSET;
      green_scaled = green_base * (DEPTH_WIDTH+9)'(GREEN_SCALE);
      green_div    = green_scaled[DEPTH_WIDTH+8:GREEN_SHIFT];
      green_third  = green_div[9:0] * 10'(RECIP3);

      if (pt_valid) begin
         rsp_x_in = proj_x;
         rsp_y_in = proj_y;
         rsp_z_in = s1_depth_ff;
         if (int'(green_div) >= GREEN_LIMIT) rsp_green_in = '1;
         else rsp_green_in = green_third[RECIP3_SHIFT+GREEN_WIDTH-1:RECIP3_SHIFT];
      end else begin
         // invalid point: zero coordinates, full green
         rsp_x_in     = '0;
         rsp_y_in     = '0;
         rsp_z_in     = '0;
         rsp_green_in = '1;
      end
      rsp_pvalid_in = pt_valid;
      rsp_valid_in  = advance ? s1_valid_ff : rsp_valid_ff;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_z_ff      <= rsp_z_in;
         rsp_pvalid_ff <= rsp_pvalid_in;
         rsp_green_ff  <= rsp_green_in;
         rsp_fend_ff   <= s1_frame_end_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_point_z     = rsp_z_ff;
   assign rsp_point_valid = rsp_pvalid_ff;
   assign rsp_green_level = rsp_green_ff;
   assign rsp_frame_end   = rsp_fend_ff;

endmodule

/* rtl/dipc_checker.sv */
// port level checks of the depth to point projection, bound to the top level
// depends on dipc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dipc_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_stall,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic signed [dipc_pkg::POINT_WIDTH-1:0]  rsp_point_x,
   input logic signed [dipc_pkg::POINT_WIDTH-1:0]  rsp_point_y,
   input logic [dipc_pkg::DEPTH_WIDTH-1:0]         rsp_point_z,
   input logic                                     rsp_point_valid,
   input logic [dipc_pkg::GREEN_WIDTH-1:0]         rsp_green_level,
   input logic                                     rsp_frame_end,
   input logic                                     csr_valid,
   input logic                                     csr_ready
);
   import dipc_pkg::*;

   localparam int PAYLOAD_WIDTH = 2*POINT_WIDTH + DEPTH_WIDTH + GREEN_WIDTH + 1;

   logic                     rsp_invalid;
   logic                     rsp_waiting;
   logic                     point_cleared;
   logic [PAYLOAD_WIDTH-1:0] rsp_payload;

   assign rsp_invalid   = rsp_valid && !rsp_point_valid;
   assign rsp_waiting   = rsp_valid && rsp_stall;
   assign point_cleared = rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0 &&
                          rsp_green_level == '1;
   assign rsp_payload   = {rsp_point_x, rsp_point_y, rsp_point_z, rsp_green_level,
                           rsp_frame_end};

   // invalid point carries zero coordinates and full green
   `DIPC_ASSERT_CLK(a_invalid_point, rsp_invalid |-> point_cleared, "invalid point not cleared")

   // a valid point has a depth above the minimum, so never zero
   `DIPC_ASSERT_CLK(a_valid_depth, rsp_valid && rsp_point_valid |-> |rsp_point_z, "zero depth point")

   // the frame restart after a register write blocks new items in the following cycle
   `DIPC_ASSERT_CLK(a_csr_restart, csr_valid && csr_ready |=> req_stall, "accept during restart")

   // a stalled result holds
   `DIPC_ASSERT_CLK(a_rsp_hold, rsp_waiting |=> rsp_valid && $stable(rsp_payload), "result changed")

endmodule

bind depth_image_to_point_cloud_core dipc_checker u_dipc_checker (.*);
